// File: rtl/core/stc_pkg.sv
// Shared types, widths and constants of the temperature compensation pipeline.
package stc_pkg;

    localparam int RAW_W       = 16;
    localparam int CAL_W       = 16;
    localparam int CFG_IDX_W   = 4;
    localparam int X1_W        = 17;
    localparam int DEN_W       = 18;
    localparam int NUM_SHIFT   = 11;
    localparam int NUM_W       = CAL_W + NUM_SHIFT;
    localparam int PROD_W      = 2 * X1_W;
    localparam int X1_SHIFT    = 15;
    localparam int Q_W         = NUM_W + 1;
    localparam int B5_W        = 32;
    localparam int T_W         = 28;
    localparam int T_SHIFT     = 4;
    localparam int T_ROUND     = 8;
    localparam int DIV_STEP_BITS = 3;
    localparam int DIV_STAGES  = NUM_W / DIV_STEP_BITS;

    localparam logic [CAL_W-1:0] AC5_RESET = 16'd32757;
    localparam logic [CAL_W-1:0] AC6_RESET = 16'd23153;
    localparam logic [CAL_W-1:0] MC_RESET  = 16'hDDF9;
    localparam logic [CAL_W-1:0] MD_RESET  = 16'd2868;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AC5 = 4'd0,
        REG_AC6 = 4'd1,
        REG_MC  = 4'd2,
        REG_MD  = 4'd3
    } stc_reg_idx_t;

    typedef struct packed {
        logic [CAL_W-1:0]        ac5;
        logic [CAL_W-1:0]        ac6;
        logic signed [CAL_W-1:0] mc;
        logic signed [CAL_W-1:0] md;
    } stc_cal_t;

    // Item state while it travels through the divider stages.
    typedef struct packed {
        logic signed [X1_W-1:0] x1;
        logic                   dz;
        logic                   neg;
        logic [DEN_W-1:0]       dvs;
        logic [DEN_W-1:0]       rem;
        logic [NUM_W-1:0]       nq;
    } stc_div_t;

endpackage

// File: rtl/core/stc_front.sv
// First two pipeline stages: offset and scale multiply, then divisor preparation.
module stc_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  stc_pkg::stc_cal_t            cal,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [stc_pkg::RAW_W-1:0]    raw_temp,
    output logic                         out_valid,
    input  logic                         out_stall,
    output stc_pkg::stc_div_t            out_data
);
    import stc_pkg::*;

    logic signed [X1_W-1:0]   diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [X1_W-1:0]   x1_reg;
    logic signed [X1_W-1:0]   x1_next;
    logic                     v1_reg;
    logic                     v2_reg;
    logic                     stall1;
    logic [DEN_W-1:0]         den;
    logic [NUM_W-1:0]         num;
    stc_div_t                 d2_reg;
    stc_div_t                 d2_next;

    assign stall1   = v2_reg && out_stall;
    assign in_stall = v1_reg && stall1;

    always_comb
    begin
        diff    = $signed({1'b0, raw_temp}) - $signed({1'b0, cal.ac6});
        prod    = diff * $signed({1'b0, cal.ac5});
        x1_next = prod[X1_SHIFT+X1_W-1:X1_SHIFT];
    end

    always_comb
    begin
        den = {x1_reg[X1_W-1], x1_reg} + {{(DEN_W-CAL_W){cal.md[CAL_W-1]}}, cal.md};
        num = {cal.mc, {NUM_SHIFT{1'b0}}};
        d2_next.x1  = x1_reg;
        d2_next.dz  = (den == '0);
        d2_next.neg = cal.mc[CAL_W-1] ^ den[DEN_W-1];
        d2_next.dvs = den[DEN_W-1] ? (~den + 1'b1) : den;
        d2_next.rem = '0;
        d2_next.nq  = cal.mc[CAL_W-1] ? (~num + 1'b1) : num;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                v1_reg <= in_valid;
            end
            if (!stall1)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            x1_reg <= x1_next;
        end
        if (!stall1 && v1_reg)
        begin
            d2_reg <= d2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = d2_reg;

endmodule

// File: rtl/core/stc_div_stage.sv
// One stage of the pipelined restoring divider, three quotient bits per stage.
module stc_div_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  stc_pkg::stc_div_t    in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output stc_pkg::stc_div_t    out_data
);
    import stc_pkg::*;

    logic               v_reg;
    stc_div_t           d_reg;
    stc_div_t           d_next;
    logic [DEN_W:0]     shifted;
    logic [DEN_W:0]     trial;

    assign in_stall = v_reg && out_stall;

    always_comb
    begin
        d_next  = in_data;
        shifted = '0;
        trial   = '0;
        for (int i = 0; i < DIV_STEP_BITS; i++)
        begin
            shifted = {d_next.rem, d_next.nq[NUM_W-1]};
            trial   = shifted - {1'b0, d_next.dvs};
            d_next.rem = trial[DEN_W] ? shifted[DEN_W-1:0] : trial[DEN_W-1:0];
            d_next.nq  = {d_next.nq[NUM_W-2:0], ~trial[DEN_W]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            d_reg <= d_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule

// File: rtl/core/stc_back.sv
// Final stage: quotient sign, zero-divisor override, sum and rounding shift.
module stc_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  stc_pkg::stc_div_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [stc_pkg::B5_W-1:0]   b5_value,
    output logic signed [stc_pkg::T_W-1:0]    temp_tenths,
    output logic                              div_zero
);
    import stc_pkg::*;

    logic                   v_reg;
    logic [Q_W-1:0]         mag;
    logic [Q_W-1:0]         q;
    logic [B5_W-1:0]        b5_next;
    logic [B5_W-1:0]        rounded;
    logic [B5_W-1:0]        b5_reg;
    logic [T_W-1:0]         t_reg;
    logic [T_W-1:0]         t_next;
    logic                   dz_reg;

    assign in_stall = v_reg && out_stall;

    always_comb
    begin
        mag = {1'b0, in_data.nq};
        q   = in_data.dz ? '0 : (in_data.neg ? (~mag + 1'b1) : mag);
        b5_next = {{(B5_W-X1_W){in_data.x1[X1_W-1]}}, in_data.x1}
                + {{(B5_W-Q_W){q[Q_W-1]}}, q};
        rounded = b5_next + B5_W'(T_ROUND);
        t_next  = rounded[T_SHIFT+T_W-1:T_SHIFT];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            b5_reg <= b5_next;
            t_reg  <= t_next;
            dz_reg <= in_data.dz;
        end
    end

    assign out_valid   = v_reg;
    assign b5_value    = $signed(b5_reg);
    assign temp_tenths = $signed(t_reg);
    assign div_zero    = dz_reg;

endmodule

// File: rtl/core/sensor_temperature_compensation.sv
// Top level of the barometric sensor temperature compensation pipeline.
// Each raw reading becomes one result: X1 = ((raw - AC6) * AC5) >>> 15, X2 = (MC << 11) / (X1 + MD),
// b5 = X1 + X2 and temperature = (b5 + 8) >>> 4 in tenths of a degree. The block takes one request
// in every clock cycle when nothing stalls. The pipeline has one stage for the multiply, one
// to form the divisor and operand magnitudes, nine stages of the restoring divider that each
// resolve three of the 27 quotient bits, and the output register. A stall on the output holds
// only the stages that are full, so bubbles close up and no request is lost. When the divisor is
// zero the correction term is forced to zero and div_zero is set. The four calibration registers
// are written through the cfg port; the user must write them only while the pipeline is empty,
// which the block itself does not enforce. Writes to indexes above three are ignored.
module sensor_temperature_compensation (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [stc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [stc_pkg::CAL_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [stc_pkg::RAW_W-1:0]         raw_temp,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [stc_pkg::B5_W-1:0]   b5_value,
    output logic signed [stc_pkg::T_W-1:0]    temp_tenths,
    output logic                              div_zero
);
    import stc_pkg::*;

    stc_cal_t cal_reg;
    stc_div_t stage_data  [0:DIV_STAGES];
    logic     stage_valid [0:DIV_STAGES];
    logic     stage_stall [0:DIV_STAGES];

    // Calibration registers, reset to the values of a typical part.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg.ac5 <= AC5_RESET;
            cal_reg.ac6 <= AC6_RESET;
            cal_reg.mc  <= MC_RESET;
            cal_reg.md  <= MD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_AC5: cal_reg.ac5 <= cfg_data;
                REG_AC6: cal_reg.ac6 <= cfg_data;
                REG_MC:  cal_reg.mc  <= cfg_data;
                REG_MD:  cal_reg.md  <= cfg_data;
                default: ;
            endcase
        end
    end

    // The multiply and the divisor setup feed the first divider stage.
    stc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cal       (cal_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .raw_temp  (raw_temp),
        .out_valid (stage_valid[0]),
        .out_stall (stage_stall[0]),
        .out_data  (stage_data[0])
    );

    // Divider chain: each stage shifts three numerator bits into the partial remainder.
    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        stc_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[g]),
            .in_stall  (stage_stall[g]),
            .in_data   (stage_data[g]),
            .out_valid (stage_valid[g+1]),
            .out_stall (stage_stall[g+1]),
            .out_data  (stage_data[g+1])
        );
    end

    // Sign correction, the sum and the rounding shift land in the output register.
    stc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (stage_valid[DIV_STAGES]),
        .in_stall    (stage_stall[DIV_STAGES]),
        .in_data     (stage_data[DIV_STAGES]),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .b5_value    (b5_value),
        .temp_tenths (temp_tenths),
        .div_zero    (div_zero)
    );

`ifndef SYNTHESIS
    // Back pressure can only come from a stalled, full output.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_stall && out_valid))
        else $error("input stalled without a stalled result at the output");

    // X1 plus a quotient of at most 2^26 in magnitude always fits in 29 bits.
    a_b5_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (b5_value[31:28] == {4{b5_value[28]}}))
        else $error("b5 result outside the reachable range");

    // With a zero divisor the result is X1 alone, a 17-bit value.
    a_dz_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && div_zero) |-> (b5_value[31:16] == {16{b5_value[16]}}))
        else $error("zero-divisor result carries a correction term");

    // The temperature and b5 of one result belong together.
    a_temp_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (temp_tenths == T_W'((b5_value + 32'sd8) >>> 4)))
        else $error("temperature does not match b5 of the same result");
`endif

endmodule

// File: sim/sensor_temperature_compensation_checker.sv
// Checker that predicts and compares every temperature compensation result.
module sensor_temperature_compensation_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [stc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [stc_pkg::CAL_W-1:0]         cfg_data,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [stc_pkg::RAW_W-1:0]         raw_temp,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic signed [stc_pkg::B5_W-1:0]   b5_value,
    input  logic signed [stc_pkg::T_W-1:0]    temp_tenths,
    input  logic                              div_zero,
    output int                                failures,
    output int                                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import stc_pkg::*;

    typedef struct {
        logic signed [B5_W-1:0] b5;
        logic signed [T_W-1:0]  tenths;
        logic                   dz;
    } reading_t;

    stc_cal_t cal;
    reading_t expected_readings[$];

    // Datasheet formula; every intermediate wraps at 32 bits.
    function automatic reading_t compensate(input logic [RAW_W-1:0] raw, input stc_cal_t c);
        logic [31:0]        diff;
        logic [31:0]        prod;
        logic signed [31:0] x1;
        logic signed [31:0] x2;
        logic signed [31:0] num;
        logic signed [31:0] den;
        logic signed [31:0] sum;
        logic signed [31:0] shifted;
        reading_t           r;
        diff = 32'(raw) - 32'(c.ac6);
        prod = diff * 32'(c.ac5);
        x1 = $signed(prod) >>> X1_SHIFT;
        num = {{16{c.mc[CAL_W-1]}}, c.mc} << NUM_SHIFT;
        den = x1 + $signed({{16{c.md[CAL_W-1]}}, c.md});
        r.dz = (den == 0);
        x2 = r.dz ? 32'sd0 : num / den;
        sum = x1 + x2;
        shifted = (sum + 32'sd8) >>> T_SHIFT;
        r.b5 = sum;
        r.tenths = shifted[T_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        reading_t want;
        if (!rst_n) begin
            cal = '{ac5: AC5_RESET, ac6: AC6_RESET, mc: MC_RESET, md: MD_RESET};
            expected_readings.delete();
            failures = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_readings.size() == 0) begin
                    $error("unexpected result: b5_value %0d", b5_value);
                    failures++;
                end else begin
                    want = expected_readings.pop_front();
                    if (b5_value !== want.b5) begin
                        $error("b5_value: expected %0d, got %0d", want.b5, b5_value);
                        failures++;
                    end
                    if (temp_tenths !== want.tenths) begin
                        $error("temp_tenths: expected %0d, got %0d", want.tenths, temp_tenths);
                        failures++;
                    end
                    if (div_zero !== want.dz) begin
                        $error("div_zero: expected %0b, got %0b", want.dz, div_zero);
                        failures++;
                    end
                end
            end
            // Requests see the calibration that held before this edge.
            if (in_valid && !in_stall)
                expected_readings.push_back(compensate(raw_temp, cal));
            if (cfg_we) begin
                case (cfg_index)
                    REG_AC5: cal.ac5 = cfg_data;
                    REG_AC6: cal.ac6 = cfg_data;
                    REG_MC:  cal.mc = cfg_data;
                    REG_MD:  cal.md = cfg_data;
                    default: ;
                endcase
            end
        end
        pending = expected_readings.size();
    end

endmodule

// File: sim/sensor_temperature_compensation_test.sv
// Top of the temperature compensation testbench: stimulus, idling and the verdict.
module sensor_temperature_compensation_test;
    timeunit 1ns;
    timeprecision 1ps;

    import stc_pkg::*;

    // Roughly how many readings the run sends, directed part included.
    localparam int ITEM_COUNT = 1950;
    // Largest gap or stall, in cycles, that either side draws for a request.
    localparam int IDLE_MAX = 11;
    // Cycles to let pass once nothing is outstanding; covers the twelve-stage pipeline.
    localparam int DRAIN_CYCLES = 24;
    // Cycles in a row with no transfer at all before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CAL_W-1:0]        cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic [RAW_W-1:0]        raw_temp;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [B5_W-1:0]  b5_value;
    logic signed [T_W-1:0]   temp_tenths;
    logic                    div_zero;

    int failures;
    int pending;
    int sent;
    int stuck;
    bit quiet;

    // Calibration as last written; used to aim readings at the zero divisor and at AC6 itself.
    logic [CAL_W-1:0]        cur_ac6;
    logic signed [CAL_W-1:0] cur_md;

    sensor_temperature_compensation dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .raw_temp    (raw_temp),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .b5_value    (b5_value),
        .temp_tenths (temp_tenths),
        .div_zero    (div_zero)
    );

    sensor_temperature_compensation_checker checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .raw_temp    (raw_temp),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .b5_value    (b5_value),
        .temp_tenths (temp_tenths),
        .div_zero    (div_zero),
        .failures    (failures),
        .pending     (pending)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Picks a calibration value: either end of the register's range, its reset value,
    // or anything at all. Zero is one of the choices as well.
    function automatic logic [CAL_W-1:0] pick_cal(input logic [CAL_W-1:0] lo,
                                                  input logic [CAL_W-1:0] hi,
                                                  input logic [CAL_W-1:0] rst_val);
        case ($urandom_range(0, 5))
            0:       return lo;
            1:       return hi;
            2:       return rst_val;
            3:       return '0;
            default: return CAL_W'($urandom);
        endcase
    endfunction

    // One calibration write. Each write raises and lowers the write enable on falling edges of its own,
    // so back-to-back writes never raise and lower it within the same time step.
    task automatic write_cal(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_AC6: cur_ac6 = value;
            REG_MD:  cur_md = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Sends one reading request. A random gap comes first; with no gap the valid stays
    // high from the previous request and only the payload changes.
    task automatic send_reading(input logic [RAW_W-1:0] raw);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, IDLE_MAX);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            raw_temp <= RAW_W'($urandom);
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        raw_temp <= raw;
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    // Brings the block to idle: no request offered, every result returned, and then a
    // further wait so the pipeline is surely empty before the calibration changes.
    task automatic drain_pipeline();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Result side: for each result it holds the stall for a random number of cycles,
    // then releases it and waits for the transfer. In quiet phases it never stalls.
    initial
    begin
        int w;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            w = quiet ? 0 : $urandom_range(0, IDLE_MAX);
            out_stall <= (w != 0);
            if (w != 0)
            begin
                repeat (w) @(negedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // Hang detection: any transfer or calibration write restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
            stuck = 0;
        else
        begin
            stuck++;
            if (stuck >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        int  target;
        int  n;
        bit  dz_phase;
        logic [RAW_W-1:0] raw;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        raw_temp = '0;
        quiet = 1'b0;
        sent = 0;
        cur_ac6 = AC6_RESET;
        cur_md = MD_RESET;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Reset calibration: both ends of the reading, the reading equal to AC6, which makes
        // the first term zero, and two alternating bit patterns.
        send_reading('0);
        send_reading('1);
        send_reading(AC6_RESET);
        send_reading(16'h5555);
        send_reading(16'hAAAA);

        // Writes to indexes beyond the last register must leave the calibration alone.
        drain_pipeline();
        for (int i = int'(REG_MD) + 1; i < 2 ** CFG_IDX_W; i++)
            write_cal(CFG_IDX_W'(i), CAL_W'($urandom));
        send_reading(16'h8000);

        // With AC5 at 2^15 the first term is just the reading minus AC6, so the divisor
        // can be steered to zero exactly.
        drain_pipeline();
        write_cal(REG_AC5, 16'h8000);
        write_cal(REG_AC6, 16'd1000);
        write_cal(REG_MD, 16'd0);
        send_reading(16'd1000);
        send_reading(16'd999);
        send_reading(16'd1001);
        drain_pipeline();
        write_cal(REG_MD, -16'sd5);
        send_reading(16'd1005);

        // Both ends of MC with a divisor of one: the correction term at its largest.
        drain_pipeline();
        write_cal(REG_MC, 16'h8000);
        write_cal(REG_MD, 16'd1);
        send_reading(16'd1000);
        drain_pipeline();
        write_cal(REG_MC, 16'h7FFF);
        send_reading(16'd1000);

        // Largest AC5 against the widest reading span: the product wraps past 32 bits,
        // in both directions, with MD at either end.
        drain_pipeline();
        write_cal(REG_AC5, 16'hFFFF);
        write_cal(REG_AC6, 16'h0000);
        write_cal(REG_MD, 16'h7FFF);
        send_reading(16'hFFFF);
        drain_pipeline();
        write_cal(REG_AC6, 16'hFFFF);
        send_reading(16'h0000);
        drain_pipeline();
        write_cal(REG_MD, 16'h8000);
        send_reading(16'h0000);

        // AC5 of zero makes the first term vanish; with MD zero every reading divides by zero.
        drain_pipeline();
        write_cal(REG_AC5, 16'h0000);
        write_cal(REG_MD, 16'h0000);
        send_reading(RAW_W'($urandom));
        send_reading(RAW_W'($urandom));

        // Random phases: a fresh calibration each time, then a burst of readings. One
        // phase in four sets AC5 to 2^15 and keeps MD small so that many readings hit
        // the zero divisor; some phases run with no gaps and no stalls at all.
        while (sent < ITEM_COUNT)
        begin
            drain_pipeline();
            dz_phase = ($urandom_range(0, 3) == 0);
            write_cal(REG_AC5, dz_phase ? 16'h8000 : pick_cal(16'h0000, 16'hFFFF, AC5_RESET));
            write_cal(REG_AC6, dz_phase ? CAL_W'($urandom_range(1000, 64535))
                                        : pick_cal(16'h0000, 16'hFFFF, AC6_RESET));
            write_cal(REG_MC, pick_cal(16'h8000, 16'h7FFF, MC_RESET));
            write_cal(REG_MD, dz_phase ? CAL_W'($urandom_range(0, 2000) - 1000)
                                       : pick_cal(16'h8000, 16'h7FFF, MD_RESET));
            if ($urandom_range(0, 7) == 0)
                write_cal(CFG_IDX_W'($urandom_range(int'(REG_MD) + 1, 2 ** CFG_IDX_W - 1)),
                          CAL_W'($urandom));
            quiet = ($urandom_range(0, 4) == 0);
            target = int'(cur_ac6) - int'(cur_md);
            n = $urandom_range(20, 120);
            repeat (n)
            begin
                case ($urandom_range(0, 7))
                    0: raw = (target >= 0 && target <= 65535) ? RAW_W'(target)
                                                              : RAW_W'($urandom);
                    1:
                    begin
                        case ($urandom_range(0, 3))
                            0:       raw = '0;
                            1:       raw = '1;
                            2:       raw = cur_ac6;
                            default: raw = cur_ac6 + 16'd1;
                        endcase
                    end
                    default: raw = RAW_W'($urandom);
                endcase
                send_reading(raw);
            end
        end

        quiet = 1'b0;
        drain_pipeline();
        if (failures == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sensor_temperature_compensation.f
rtl/core/stc_pkg.sv
rtl/core/stc_front.sv
rtl/core/stc_div_stage.sv
rtl/core/stc_back.sv
rtl/core/sensor_temperature_compensation.sv
sim/sensor_temperature_compensation_checker.sv
sim/sensor_temperature_compensation_test.sv
